/* rtl/bhf_pkg.sv */
package bhf_pkg;

	// Telemetry snapshot carried by one tick item
	typedef struct packed {
		logic [12:0]        max_cell_mv;
		logic [12:0]        min_cell_mv;
		logic signed [11:0] max_temp_dc;
		logic [15:0]        pack_voltage_cv;
		logic signed [15:0] pack_current_da;
		logic [6:0]         soc_pct;
		logic [6:0]         soh_pct;
		logic               link_a_online;
		logic               comm_ok;
		logic               pack_a_online;
		logic               pack_b_online;
	} bhf_in_t;

	// One CAN frame item
	typedef struct packed {
		logic [10:0] frame_id;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [7:0]  byte3;
		logic [7:0]  byte4;
		logic [7:0]  byte5;
		logic [7:0]  byte6;
		logic [7:0]  byte7;
		logic        last_frame;
		logic [31:0] frames_sent;
	} bhf_out_t;

	// Configuration register file contents
	typedef struct packed {
		logic        enable;
		logic [15:0] heartbeat_period;
		logic [15:0] charge_voltage_limit;
		logic [15:0] cutoff_voltage;
		logic [15:0] charge_current_full;
		logic [15:0] discharge_current_full;
	} bhf_cfg_t;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHG_V_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_V    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHG_I_FULL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DCHG_I_FULL = 3'd5;

	localparam logic        RST_ENABLE      = 1'b1;
	localparam logic [15:0] RST_PERIOD      = 16'd1000;
	localparam logic [15:0] RST_CHG_V_LIMIT = 16'd568;
	localparam logic [15:0] RST_CUTOFF_V    = 16'd448;
	localparam logic [15:0] RST_CHG_I_FULL  = 16'd2500;
	localparam logic [15:0] RST_DCHG_I_FULL = 16'd2500;

	// Frame slots within a burst
	localparam int FRAME_IDX_W = 3;
	localparam logic [FRAME_IDX_W-1:0] FRM_LIMITS = 3'd0;
	localparam logic [FRAME_IDX_W-1:0] FRM_SOC    = 3'd1;
	localparam logic [FRAME_IDX_W-1:0] FRM_MEAS   = 3'd2;
	localparam logic [FRAME_IDX_W-1:0] FRM_ALARM  = 3'd3;
	localparam logic [FRAME_IDX_W-1:0] FRM_REQ    = 3'd4;
	localparam logic [FRAME_IDX_W-1:0] FRM_NAME   = 3'd5;

	localparam logic [10:0] ID_LIMITS = 11'h351;
	localparam logic [10:0] ID_SOC    = 11'h355;
	localparam logic [10:0] ID_MEAS   = 11'h356;
	localparam logic [10:0] ID_ALARM  = 11'h359;
	localparam logic [10:0] ID_REQ    = 11'h35C;
	localparam logic [10:0] ID_NAME   = 11'h35E;

	// Cell voltage thresholds, mV
	localparam logic [12:0] CELL_FULL_MV  = 13'd3650;
	localparam logic [12:0] CELL_HIGH_MV  = 13'd3500;
	localparam logic [12:0] CELL_TAPER_MV = 13'd3420;
	localparam logic [12:0] CELL_EMPTY_MV = 13'd2800;

	localparam logic [15:0] CHG_I_HIGH  = 16'd200;
	localparam logic [15:0] CHG_I_TAPER = 16'd800;

	localparam logic signed [11:0] TEMP_ALARM_DC   = 12'sd550;
	localparam logic [15:0]        TEMP_DEFAULT_DC = 16'd245;
	localparam logic [15:0]        PACK_V_MIN_CV   = 16'd4000;
	localparam logic [15:0]        PACK_V_DFLT_CV  = 16'd5340;
	localparam logic [6:0]         SOH_DEFAULT     = 7'd100;

	localparam logic [7:0] ALM_CELL_HIGH = 8'h04;
	localparam logic [7:0] ALM_CELL_LOW  = 8'h10;
	localparam logic [7:0] ALM_TEMP_HIGH = 8'h01;
	localparam logic [7:0] PACKS_ONE     = 8'd1;
	localparam logic [7:0] PACKS_TWO     = 8'd2;

	// Name frame text, eight ASCII bytes
	localparam logic [63:0] NAME_TEXT = 64'h50_59_4C_4F_4E_20_20_20;

endpackage

/* rtl/bhf_cfg_regs.sv */
module bhf_cfg_regs
	import bhf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output bhf_cfg_t              cfg
);

	bhf_cfg_t cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable                 <= RST_ENABLE;
			cfg_q.heartbeat_period       <= RST_PERIOD;
			cfg_q.charge_voltage_limit   <= RST_CHG_V_LIMIT;
			cfg_q.cutoff_voltage         <= RST_CUTOFF_V;
			cfg_q.charge_current_full    <= RST_CHG_I_FULL;
			cfg_q.discharge_current_full <= RST_DCHG_I_FULL;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ENABLE:      cfg_q.enable                 <= cfg_wdata[0];
				REG_PERIOD:      cfg_q.heartbeat_period       <= cfg_wdata;
				REG_CHG_V_LIMIT: cfg_q.charge_voltage_limit   <= cfg_wdata;
				REG_CUTOFF_V:    cfg_q.cutoff_voltage         <= cfg_wdata;
				REG_CHG_I_FULL:  cfg_q.charge_current_full    <= cfg_wdata;
				REG_DCHG_I_FULL: cfg_q.discharge_current_full <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/bhf_tick_ctrl.sv */
module bhf_tick_ctrl
	import bhf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  bhf_cfg_t cfg,
	input  logic     accept,
	input  logic     link_up,
	output logic     fire
);

	logic [15:0] tick_q;
	logic [15:0] tick_next;
	logic [15:0] period;
	logic        due;

	// A zero period acts as one; a count past the period fires at once
	assign period    = (cfg.heartbeat_period == '0) ? 16'd1 : cfg.heartbeat_period;
	assign tick_next = tick_q + 16'd1;
	assign due       = (tick_next >= period) || (tick_next == '0);
	assign fire      = cfg.enable && due && link_up;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (accept && cfg.enable) begin
			tick_q <= due ? '0 : tick_next;
		end
	end

endmodule

/* rtl/bhf_frame_build.sv */
module bhf_frame_build
	import bhf_pkg::*;
(
	input  bhf_in_t                snap,
	input  bhf_cfg_t               cfg,
	input  logic [FRAME_IDX_W-1:0] idx,
	input  logic [31:0]            total,
	output bhf_out_t               frame
);

	logic [15:0] chg;
	logic [15:0] dchg;
	logic [15:0] pv_word;
	logic [15:0] temp_word;
	logic [15:0] cur_word;
	logic [6:0]  soh;
	logic [7:0]  alarm;
	logic [7:0]  req;
	logic        cell_full;
	logic        cell_empty;

	// Limits, defaults and flags used by the frame payloads
	always_comb begin
		cell_full  = snap.max_cell_mv >= CELL_FULL_MV;
		cell_empty = snap.min_cell_mv <= CELL_EMPTY_MV;
		if (cell_full)
			chg = '0;
		else if (snap.max_cell_mv >= CELL_HIGH_MV)
			chg = CHG_I_HIGH;
		else if (snap.max_cell_mv >= CELL_TAPER_MV)
			chg = CHG_I_TAPER;
		else
			chg = cfg.charge_current_full;
		dchg      = cell_empty ? '0 : cfg.discharge_current_full;
		soh       = (snap.soh_pct == '0) ? SOH_DEFAULT : snap.soh_pct;
		pv_word   = (snap.pack_voltage_cv <= PACK_V_MIN_CV) ? PACK_V_DFLT_CV
			: snap.pack_voltage_cv;
		// positive temperature, so zero-extension equals sign extension
		temp_word = (snap.max_temp_dc > 12'sd0) ? {4'b0, snap.max_temp_dc}
			: TEMP_DEFAULT_DC;
		cur_word  = snap.pack_current_da;
		alarm     = (cell_full ? ALM_CELL_HIGH : 8'h00)
			| (cell_empty ? ALM_CELL_LOW : 8'h00)
			| ((snap.max_temp_dc >= TEMP_ALARM_DC) ? ALM_TEMP_HIGH : 8'h00);
		req       = {(chg != '0), (dchg != '0), 6'b0};
	end

	// Payload selection by slot
	always_comb begin
		frame             = '0;
		frame.frames_sent = total;
		case (idx)
			FRM_LIMITS: begin
				frame.frame_id = ID_LIMITS;
				{frame.byte1, frame.byte0} = cfg.charge_voltage_limit;
				{frame.byte3, frame.byte2} = chg;
				{frame.byte5, frame.byte4} = dchg;
				{frame.byte7, frame.byte6} = cfg.cutoff_voltage;
			end
			FRM_SOC: begin
				frame.frame_id = ID_SOC;
				frame.byte0    = {1'b0, snap.soc_pct};
				frame.byte2    = {1'b0, soh};
			end
			FRM_MEAS: begin
				frame.frame_id = ID_MEAS;
				{frame.byte1, frame.byte0} = pv_word;
				{frame.byte3, frame.byte2} = cur_word;
				{frame.byte5, frame.byte4} = temp_word;
			end
			FRM_ALARM: begin
				frame.frame_id = ID_ALARM;
				frame.byte0    = alarm;
				frame.byte4    = (snap.pack_a_online && snap.pack_b_online) ? PACKS_TWO
					: PACKS_ONE;
			end
			FRM_REQ: begin
				frame.frame_id = ID_REQ;
				frame.byte0    = req;
			end
			FRM_NAME: begin
				frame.frame_id   = ID_NAME;
				{frame.byte0, frame.byte1, frame.byte2, frame.byte3,
					frame.byte4, frame.byte5, frame.byte6, frame.byte7} = NAME_TEXT;
				frame.last_frame = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/bhf_burst_seq.sv */
module bhf_burst_seq
	import bhf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  bhf_cfg_t cfg,
	input  logic     start,
	input  bhf_in_t  in_data,
	output logic     busy,
	output logic     out_valid,
	input  logic     out_ready,
	output bhf_out_t out_data
);

	bhf_in_t                snap_s1;
	logic                   active_q;
	logic [FRAME_IDX_W-1:0] idx_q;
	logic [31:0]            total_q;
	logic                   out_valid_q;
	bhf_out_t               out_q;
	bhf_out_t               frame;
	logic                   load;

	// Output register free or draining this cycle
	assign load = active_q && (!out_valid_q || out_ready);

	bhf_frame_build u_build (
		.snap  (snap_s1),
		.cfg   (cfg),
		.idx   (idx_q),
		.total (total_q + 32'd1),
		.frame (frame)
	);

	// Snapshot of the tick that opened the burst
	always_ff @(posedge clk) begin
		if (start)
			snap_s1 <= in_data;
	end

	// Slot counter and running frame count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= FRM_LIMITS;
			total_q  <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			idx_q    <= FRM_LIMITS;
		end else if (load) begin
			total_q <= total_q + 32'd1;
			idx_q   <= idx_q + 1'b1;
			if (idx_q == FRM_NAME)
				active_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= frame;
	end

	assign busy      = active_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/bms_can_heartbeat_framer_unit.sv */
// Battery status CAN framer. Each input item is one millisecond tick with a
// telemetry snapshot. While enabled the block counts ticks; when the count
// reaches heartbeat_period (zero acts as one) the count restarts and, if
// either telemetry link is up, a burst of six frames 0x351, 0x355, 0x356,
// 0x359, 0x35C, 0x35E follows, one per cycle while out_ready is high, with
// last_frame on 0x35E. A tick opening no burst leaves in_ready high, so ticks
// may arrive back to back; one opening a burst holds in_ready low until all
// six frames are loaded (longer if out_ready stalls); a new tick is taken
// while the final frame still waits. The user must write configuration
// through cfg_we/cfg_idx/cfg_wdata only while no burst is pending; the
// block does not enforce it. Ticks go via the snapshot and output registers.
module bms_can_heartbeat_framer_unit
	import bhf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bhf_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bhf_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	bhf_cfg_t cfg;
	logic     accept;
	logic     fire;
	logic     busy;

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;

	bhf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bhf_tick_ctrl u_tick (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.link_up (in_data.link_a_online || in_data.comm_ok),
		.fire    (fire)
	);

	bhf_burst_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (accept && fire),
		.in_data   (in_data),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* rtl/bhf_checker.sv */
module bhf_checker
	import bhf_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input bhf_out_t              out_data
);

	// A stalled frame holds
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("frame changed while stalled");

	// Frame count advances by one per delivered frame
	ast_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid
			|| out_data.frames_sent == $past(out_data.frames_sent) + 32'd1)
		else $error("frame count skipped");

	// Only the name frame closes a burst
	ast_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.last_frame == (out_data.frame_id == ID_NAME))
		else $error("last_frame on wrong frame");

	// Inside a burst the next frame follows at once and no tick is taken
	ast_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_frame |=> out_valid)
		else $error("gap inside burst");

	ast_burst_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_frame |-> !in_ready)
		else $error("tick taken during burst");

endmodule

bind bms_can_heartbeat_framer_unit bhf_checker u_bhf_checker (.*);
